>>> hdl/led_ring_animation_frame_unit_macros.svh
// Assertion macros used by the checker file of the animation frame unit.
`ifndef LED_RING_ANIMATION_FRAME_UNIT_MACROS_SVH
`define LED_RING_ANIMATION_FRAME_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LRAF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LRAF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/lraf_pkg.sv
// Types and constants shared by the LED ring animation frame unit.
`default_nettype none

package lraf_pkg;

	// Pixel counter and step-position width, covering strips of up to 64 pixels
	localparam int PIX_W = 6;

	// Step counter: increments while at or below this value, then wraps to 0
	localparam logic [4:0] STEP_LAST_INC = 5'd23;

	// Pulse blend, in thousandths
	localparam logic [9:0] T_PER_STEP = 10'd41;
	localparam logic [9:0] T_FULL     = 10'd1000;

	// Blend divide: floor(x/1000) == (x * 67109) >> 26 for x < 2^18
	localparam logic [16:0] BLEND_RECIP = 17'd67109;

	// Brightness scale: floor(x/100) == (x * 10486) >> 20 for x < 2^15
	localparam logic [13:0] SCALE_RECIP = 14'd10486;

	// Descriptor queue depth
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_MODE         = 3'd0,
		CFG_COLOR_FIRST  = 3'd1,
		CFG_COLOR_SECOND = 3'd2,
		CFG_SPIN_WIDTH   = 3'd3,
		CFG_BRIGHTNESS   = 3'd4
	} lraf_cfg_idx_t;

	// Reset values of the configuration registers
	localparam logic        RST_MODE         = 1'b0;
	localparam logic [23:0] RST_COLOR_FIRST  = 24'h0000FF;
	localparam logic [23:0] RST_COLOR_SECOND = 24'h00FFFF;
	localparam logic [4:0]  RST_SPIN_WIDTH   = 5'd2;
	localparam logic [6:0]  RST_BRIGHTNESS   = 7'd15;

	// Configuration as seen by the frame engine
	typedef struct packed {
		logic        mode;
		logic [23:0] color_first;
		logic [23:0] color_second;
		logic [4:0]  spin_width;
		logic [6:0]  brightness;
	} lraf_cfg_t;

	// One frame job: blend position and spinner start pixel
	typedef struct packed {
		logic [9:0]       t;
		logic [PIX_W-1:0] start;
	} lraf_desc_t;

endpackage

`default_nettype wire

>>> hdl/lraf_front.sv
// Tick intake: step counter, pulse direction and frame job build.
`default_nettype none

module lraf_front import lraf_pkg::*; #(
	parameter int PIXEL_COUNT = 24
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       advance,
	input  wire logic       full,
	output logic            in_stall,
	output logic            push,
	output lraf_desc_t      desc
);

	logic [4:0]       step_q;
	logic             rising_q;
	logic [PIX_W-1:0] start_q;

	logic [4:0]       step_nxt;
	logic             rising_nxt;
	logic [PIX_W-1:0] start_nxt;
	logic [PIX_W-1:0] start_inc;
	logic [9:0]       t_rise;

	assign in_stall = full;
	assign push     = in_valid && !full;

	// Next step, direction and start pixel (start tracks step modulo strip length)
	always_comb begin
		start_inc = start_q + PIX_W'(1);
		if (advance) begin
			step_nxt = (step_q <= STEP_LAST_INC) ? step_q + 5'd1 : 5'd0;
			rising_nxt = (step_nxt == 5'd0) ? !rising_q : rising_q;
			if (step_nxt == 5'd0) begin
				start_nxt = '0;
			end else if ({1'b0, start_inc} == (PIX_W + 1)'(PIXEL_COUNT)) begin
				start_nxt = '0;
			end else begin
				start_nxt = start_inc;
			end
		end else begin
			step_nxt   = step_q;
			rising_nxt = rising_q;
			start_nxt  = start_q;
		end
	end

	// Blend position in thousandths
	assign t_rise     = 10'(step_nxt) * T_PER_STEP;
	assign desc.t     = rising_nxt ? t_rise : T_FULL - t_rise;
	assign desc.start = start_nxt;

	// Animation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			rising_q <= 1'b1;
			start_q  <= '0;
		end else if (push) begin
			step_q   <= step_nxt;
			rising_q <= rising_nxt;
			start_q  <= start_nxt;
		end
	end

endmodule

`default_nettype wire

>>> hdl/lraf_queue.sv
// Short job queue between tick intake and frame engine.
`default_nettype none

module lraf_queue import lraf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire lraf_desc_t  wr_desc,
	input  wire logic        pop,
	output lraf_desc_t       rd_desc,
	output logic             full,
	output logic             empty
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	lraf_desc_t     slot_q [QUEUE_DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    count_q;

	assign full    = (count_q == (AW + 1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_desc = slot_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_desc;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/lraf_back.sv
// Frame engine: pulse blend, pixel sequencer and brightness pipeline.
`default_nettype none

module lraf_back import lraf_pkg::*; #(
	parameter int PIXEL_COUNT = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lraf_cfg_t   cfg,
	input  wire logic        empty,
	input  wire lraf_desc_t  desc,
	output logic             pop,
	input  wire logic        out_stall,
	output logic             out_valid,
	output logic [4:0]       pixel_index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic             frame_end
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EMIT = 4'b1000
	} lraf_state_t;

	localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(PIXEL_COUNT - 1);
	localparam logic [PIX_W:0]   PIX_NUM  = (PIX_W + 1)'(PIXEL_COUNT);

	// Brightness: floor(x/100) saturated to 8 bits
	function automatic logic [7:0] scale_sat(input logic [14:0] x);
		logic [28:0] prod;
		prod = 29'(x) * 29'(SCALE_RECIP);
		return (prod[28:20] > 9'd255) ? 8'hFF : prod[27:20];
	endfunction

	lraf_state_t       state_q;
	logic [9:0]        t_q;
	logic [PIX_W-1:0]  start_q;
	logic [1:0]        ch_q;
	logic [17:0]       num_q;
	logic [23:0]       pulse_q;
	logic [PIX_W-1:0]  pix_q;

	logic              adv;
	logic              issue;
	logic [7:0]        ch_a;
	logic [7:0]        ch_b;
	logic [17:0]       blend_num;
	logic [33:0]       blend_prod;
	logic [7:0]        blend_quot;
	logic [PIX_W:0]    offset;
	logic              lit;
	logic [23:0]       pix_color;

	// Pipeline registers
	logic              valid_s1;
	logic [23:0]       col_s1;
	logic [PIX_W-1:0]  idx_s1;
	logic              end_s1;
	logic              valid_s2;
	logic [14:0]       prod_r_s2;
	logic [14:0]       prod_g_s2;
	logic [14:0]       prod_b_s2;
	logic [PIX_W-1:0]  idx_s2;
	logic              end_s2;
	logic              out_valid_q;
	logic [4:0]        pixel_index_q;
	logic [7:0]        red_q;
	logic [7:0]        green_q;
	logic [7:0]        blue_q;
	logic              frame_end_q;

	// Whole pipeline moves when the output slot is free or being taken
	assign adv   = !out_valid_q || !out_stall;
	assign issue = (state_q == ST_EMIT) && adv;
	assign pop   = (state_q == ST_IDLE) && !empty;

	// Channel operands of the blend (0 blue, 1 green, 2 red)
	always_comb begin
		unique case (ch_q)
			2'd0: begin
				ch_a = cfg.color_first[7:0];
				ch_b = cfg.color_second[7:0];
			end
			2'd1: begin
				ch_a = cfg.color_first[15:8];
				ch_b = cfg.color_second[15:8];
			end
			2'd2: begin
				ch_a = cfg.color_first[23:16];
				ch_b = cfg.color_second[23:16];
			end
			default: begin
				ch_a = '0;
				ch_b = '0;
			end
		endcase
	end

	assign blend_num = 18'(ch_a) * 18'(T_FULL - t_q) + 18'(ch_b) * 18'(t_q);

	// Divide the registered weighted sum by 1000 through the reciprocal
	assign blend_prod = 34'(num_q) * 34'(BLEND_RECIP);
	assign blend_quot = blend_prod[33:26];

	// Spinner: offset from start pixel, wrapped around the strip
	always_comb begin
		if (pix_q >= start_q) begin
			offset = {1'b0, pix_q} - {1'b0, start_q};
		end else begin
			offset = {1'b0, pix_q} + PIX_NUM - {1'b0, start_q};
		end
		lit = ((PIX_W + 1)'(cfg.spin_width) >= PIX_NUM) ||
			(offset < (PIX_W + 1)'(cfg.spin_width));
		if (cfg.mode) begin
			pix_color = pulse_q;
		end else begin
			pix_color = lit ? cfg.color_second : cfg.color_first;
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						state_q <= cfg.mode ? ST_LOAD : ST_EMIT;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (ch_q == 2'd2) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_EMIT: begin
					if (issue && pix_q == PIX_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				t_q     <= desc.t;
				start_q <= desc.start;
				ch_q    <= 2'd0;
				pix_q   <= '0;
			end
			ST_LOAD: begin
				num_q <= blend_num;
			end
			ST_DIV: begin
				ch_q <= ch_q + 2'd1;
				unique case (ch_q)
					2'd0: pulse_q[7:0] <= blend_quot;
					2'd1: pulse_q[15:8] <= blend_quot;
					2'd2: pulse_q[23:16] <= blend_quot;
					default: pulse_q <= pulse_q;
				endcase
			end
			ST_EMIT: begin
				if (issue) begin
					pix_q <= pix_q + PIX_W'(1);
				end
			end
			default: begin
				pix_q <= '0;
			end
		endcase
	end

	// Valid bits of the pixel pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= issue;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Pixel pipeline: color select, brightness product, reciprocal scale
	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1        <= pix_color;
			idx_s1        <= pix_q;
			end_s1        <= (pix_q == PIX_LAST);
			prod_r_s2     <= 15'(col_s1[23:16]) * 15'(cfg.brightness);
			prod_g_s2     <= 15'(col_s1[15:8]) * 15'(cfg.brightness);
			prod_b_s2     <= 15'(col_s1[7:0]) * 15'(cfg.brightness);
			idx_s2        <= idx_s1;
			end_s2        <= end_s1;
			red_q         <= scale_sat(prod_r_s2);
			green_q       <= scale_sat(prod_g_s2);
			blue_q        <= scale_sat(prod_b_s2);
			pixel_index_q <= 5'(idx_s2);
			frame_end_q   <= end_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = pixel_index_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;
	assign frame_end   = frame_end_q;

endmodule

`default_nettype wire

>>> hdl/led_ring_animation_frame_unit.sv
// LED ring animation frame unit: one tick in, PIXEL_COUNT colored pixels out.
// Pixels pass the color-select, brightness-product and scale registers; pulse mode first
// blends each channel in a sum state and a divide state before the pixels go out. A frame
// emits one pixel per cycle unless the output stalls, and the next tick waits in the queue.
// Ticks queue two deep ahead of the frame engine; output stalls hold the pipeline.
// Reset (arst_n low): step 0, rising, queue and pipeline empty, registers at defaults.
`default_nettype none

module led_ring_animation_frame_unit import lraf_pkg::*; #(
	parameter int PIXEL_COUNT = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        advance,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       pixel_index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic             frame_end,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	lraf_cfg_t  cfg_q;
	logic       push;
	logic       pop;
	logic       full;
	logic       empty;
	lraf_desc_t wr_desc;
	lraf_desc_t rd_desc;

	assign cfg_ready = 1'b1;

	// Configuration registers; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= RST_MODE;
			cfg_q.color_first  <= RST_COLOR_FIRST;
			cfg_q.color_second <= RST_COLOR_SECOND;
			cfg_q.spin_width   <= RST_SPIN_WIDTH;
			cfg_q.brightness   <= RST_BRIGHTNESS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE:         cfg_q.mode         <= cfg_data[0];
				CFG_COLOR_FIRST:  cfg_q.color_first  <= cfg_data;
				CFG_COLOR_SECOND: cfg_q.color_second <= cfg_data;
				CFG_SPIN_WIDTH:   cfg_q.spin_width   <= cfg_data[4:0];
				CFG_BRIGHTNESS:   cfg_q.brightness   <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	lraf_front #(.PIXEL_COUNT(PIXEL_COUNT)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.advance  (advance),
		.full     (full),
		.in_stall (in_stall),
		.push     (push),
		.desc     (wr_desc)
	);

	lraf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_desc (wr_desc),
		.pop     (pop),
		.rd_desc (rd_desc),
		.full    (full),
		.empty   (empty)
	);

	lraf_back #(.PIXEL_COUNT(PIXEL_COUNT)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.empty       (empty),
		.desc        (rd_desc),
		.pop         (pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.frame_end   (frame_end)
	);

endmodule

`default_nettype wire

>>> hdl/lraf_checker.sv
// Port-level checks of the animation frame unit and their bind.
`default_nettype none

`include "led_ring_animation_frame_unit_macros.svh"

module lraf_checker #(
	parameter int PIXEL_COUNT = 24
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [4:0]  pixel_index,
	input wire logic [7:0]  red,
	input wire logic [7:0]  green,
	input wire logic [7:0]  blue,
	input wire logic        frame_end
);

	localparam logic [4:0] LAST_IDX = 5'(PIXEL_COUNT - 1);

	// A stalled pixel stays put
	`LRAF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_index) && $stable(red) && $stable(green) && $stable(blue) && $stable(frame_end), "stalled pixel changed")

	// The frame closes on the last pixel
	`LRAF_ASSERT_NOW(a_frame_end_idx, out_valid && frame_end, pixel_index == LAST_IDX, "frame_end off the last pixel")

	// Pixels of a frame stream back to back in index order
	`LRAF_ASSERT_NEXT(a_pixel_seq, out_valid && !out_stall && !frame_end, out_valid && pixel_index == $past(pixel_index) + 5'd1, "pixel sequence broken")

	// A pixel right after a frame's end is pixel zero
	`LRAF_ASSERT_NEXT(a_frame_start, out_valid && !out_stall && frame_end, !out_valid || pixel_index == 5'd0, "frame did not start at pixel zero")

endmodule

bind led_ring_animation_frame_unit lraf_checker #(.PIXEL_COUNT(PIXEL_COUNT)) u_lraf_checker (.*);

`default_nettype wire

>>> tb/tb_led_ring_animation_frame_unit.sv
// Self-checking testbench for the LED ring animation frame unit, with random idling on both sides.
module tb_led_ring_animation_frame_unit;
	import lraf_pkg::*;

	localparam int PIXELS        = 24;
	localparam int WATCHDOG_MAX  = 2000;
	localparam int TICK_TARGET   = 150;
	localparam int QUIET_FROM    = 120;
	localparam int SETTLE_CYCLES = 40;
	localparam int REG_SETTLE    = 8;

	// One pixel as the block emits it
	typedef struct packed {
		logic [4:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       last;
	} pixel_t;

	// Directed script entry: a register write or a tick, with an optional uniform frame color
	typedef struct packed {
		logic          is_cfg;
		lraf_cfg_idx_t reg_idx;
		logic [23:0]   data;
		logic          adv;
		logic          known;
		logic [23:0]   known_rgb;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        advance;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  pixel_index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        frame_end;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	// Shadow registers and animation state
	logic        sh_mode   = RST_MODE;
	logic [23:0] sh_first  = RST_COLOR_FIRST;
	logic [23:0] sh_second = RST_COLOR_SECOND;
	logic [4:0]  sh_width  = RST_SPIN_WIDTH;
	logic [6:0]  sh_bright = RST_BRIGHTNESS;
	logic [4:0]  step_q    = 5'd0;
	logic        rising_q  = 1'b1;

	pixel_t      pending_pixels[$];
	int unsigned mismatches  = 0;
	int unsigned idle_cycles = 0;
	int unsigned hold_left   = 0;
	int unsigned calm_left   = 0;
	logic        quiet       = 1'b0;

	led_ring_animation_frame_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.advance     (advance),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.frame_end   (frame_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Brightness scale with saturation
	function automatic logic [7:0] dim(input logic [7:0] c, input logic [6:0] pct);
		int unsigned v;
		v = (int'(c) * int'(pct)) / 100;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	// Linear blend in thousandths, truncated
	function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
			input int unsigned t);
		int unsigned v;
		v = (int'(a) * (1000 - t) + int'(b) * t) / 1000;
		return v[7:0];
	endfunction

	function automatic script_row_t cfg_row(input lraf_cfg_idx_t i, input logic [23:0] d);
		return {1'b1, i, d, 1'b0, 1'b0, 24'h0};
	endfunction

	function automatic script_row_t tick_row(input logic a, input logic k, input logic [23:0] rgb);
		return {1'b0, CFG_MODE, 24'h0, a, k, rgb};
	endfunction

	// Step the animation and queue the 24 pixels of the resulting frame
	task automatic paint_frame(input logic adv, input logic known, input logic [23:0] known_rgb);
		int unsigned t;
		int unsigned start;
		int unsigned offset;
		logic        lit;
		logic [23:0] pulse;
		logic [23:0] col;
		pixel_t      px;
		if (adv) begin
			step_q = (step_q <= 5'd23) ? step_q + 5'd1 : 5'd0;
			if (step_q == 5'd0)
				rising_q = ~rising_q;
		end
		t = step_q * 41;
		if (!rising_q)
			t = 1000 - t;
		for (int sh = 0; sh < 24; sh += 8)
			pulse[sh +: 8] = mix(sh_first[sh +: 8], sh_second[sh +: 8], t);
		start = step_q % PIXELS;
		for (int p = 0; p < PIXELS; p++) begin
			offset  = (p + PIXELS - start) % PIXELS;
			lit     = (sh_width >= PIXELS) || (offset < sh_width);
			col     = sh_mode ? pulse : (lit ? sh_second : sh_first);
			px.idx  = p[4:0];
			px.r    = known ? known_rgb[23:16] : dim(col[23:16], sh_bright);
			px.g    = known ? known_rgb[15:8] : dim(col[15:8], sh_bright);
			px.b    = known ? known_rgb[7:0] : dim(col[7:0], sh_bright);
			px.last = (p == PIXELS - 1);
			pending_pixels.push_back(px);
		end
	endtask

	// Present one tick and wait for its transfer; valid stays high afterwards
	task automatic send_tick(input logic adv, input logic known, input logic [23:0] rgb);
		in_valid  <= 1'b1;
		advance   <= adv;
		cfg_valid <= 1'b0;
		do @(posedge clk); while (in_stall);
		paint_frame(adv, known, rgb);
	endtask

	// Register write; valid stays high until the next tick lowers it
	task automatic write_reg(input lraf_cfg_idx_t i, input logic [23:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= i;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		case (i)
			CFG_MODE:         sh_mode   = d[0];
			CFG_COLOR_FIRST:  sh_first  = d;
			CFG_COLOR_SECOND: sh_second = d;
			CFG_SPIN_WIDTH:   sh_width  = d[4:0];
			CFG_BRIGHTNESS:   sh_bright = d[6:0];
			default: ;
		endcase
	endtask

	// Let every queued frame come out, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
		repeat (REG_SETTLE) @(posedge clk);
	endtask

	// Random input idling between ticks
	task automatic input_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			advance  <= 1'($urandom_range(0, 1));
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// Output stall: random bursts, calm stretches, none in the tail
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (quiet || calm_left != 0) begin
				out_stall <= 1'b0;
				if (calm_left != 0)
					calm_left--;
			end else begin
				case ($urandom_range(0, 9))
					0: begin
						out_stall <= 1'b1;
						hold_left = $urandom_range(0, 8);
					end
					1: begin
						out_stall <= 1'b0;
						calm_left = $urandom_range(20, 80);
					end
					default: out_stall <= 1'b0;
				endcase
			end
		end
	end

	// Pixel checker and watchdog
	always @(posedge clk) begin : check_pixels
		pixel_t got;
		pixel_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {pixel_index, red, green, blue, frame_end};
				if (pending_pixels.size() == 0) begin
					mismatches++;
					$display({"%0t: unexpected pixel, expected none, got idx=%0d",
						" rgb=%02h_%02h_%02h end=%0b"},
						$time, got.idx, got.r, got.g, got.b, got.last);
				end else begin
					want = pending_pixels.pop_front();
					if (got !== want) begin
						mismatches++;
						$display({"%0t: pixel mismatch, expected idx=%0d rgb=%02h_%02h_%02h",
							" end=%0b, got idx=%0d rgb=%02h_%02h_%02h end=%0b"},
							$time, want.idx, want.r, want.g, want.b, want.last,
							got.idx, got.r, got.g, got.b, got.last);
					end
				end
			end
			if ((in_valid && !in_stall) || (cfg_valid && cfg_ready) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin : stimulus
		script_row_t   script[$];
		lraf_cfg_idx_t ri;
		logic [23:0]   val;
		logic          ticked;
		int unsigned   ticks;
		int unsigned   burst;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		advance   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data  = 24'h0;

		// Reset frame, then first step
		script.push_back(tick_row(1'b0, 1'b0, 24'h0));
		script.push_back(tick_row(1'b1, 1'b0, 24'h0));
		// Zero brightness blanks everything
		script.push_back(cfg_row(CFG_BRIGHTNESS, 24'd0));
		script.push_back(tick_row(1'b1, 1'b1, 24'h000000));
		// Full-strip spinner, brightness over 100 saturates
		script.push_back(cfg_row(CFG_COLOR_SECOND, 24'hFFFFFF));
		script.push_back(cfg_row(CFG_SPIN_WIDTH, 24'd24));
		script.push_back(cfg_row(CFG_BRIGHTNESS, 24'd127));
		script.push_back(tick_row(1'b0, 1'b1, 24'hFFFFFF));
		script.push_back(cfg_row(CFG_SPIN_WIDTH, 24'd31));
		script.push_back(tick_row(1'b1, 1'b1, 24'hFFFFFF));
		// Zero width: background only
		script.push_back(cfg_row(CFG_COLOR_FIRST, 24'hA55AC3));
		script.push_back(cfg_row(CFG_SPIN_WIDTH, 24'd0));
		script.push_back(cfg_row(CFG_BRIGHTNESS, 24'd100));
		script.push_back(tick_row(1'b1, 1'b1, 24'hA55AC3));
		// Narrowest and widest partial spinners
		script.push_back(cfg_row(CFG_COLOR_FIRST, 24'h000000));
		script.push_back(cfg_row(CFG_SPIN_WIDTH, 24'd1));
		script.push_back(tick_row(1'b1, 1'b0, 24'h0));
		script.push_back(cfg_row(CFG_SPIN_WIDTH, 24'd23));
		script.push_back(tick_row(1'b1, 1'b0, 24'h0));
		// Pulse between equal colors stays put
		script.push_back(cfg_row(CFG_MODE, 24'd1));
		script.push_back(cfg_row(CFG_COLOR_FIRST, 24'h5A3C96));
		script.push_back(cfg_row(CFG_COLOR_SECOND, 24'h5A3C96));
		script.push_back(tick_row(1'b1, 1'b1, 24'h5A3C96));
		// Pulse across the full range
		script.push_back(cfg_row(CFG_COLOR_FIRST, 24'h000000));
		script.push_back(cfg_row(CFG_COLOR_SECOND, 24'hFFFFFF));
		script.push_back(tick_row(1'b1, 1'b0, 24'h0));
		script.push_back(tick_row(1'b0, 1'b0, 24'h0));
		script.push_back(cfg_row(CFG_COLOR_FIRST, 24'hFF00FF));
		script.push_back(cfg_row(CFG_COLOR_SECOND, 24'h00FF00));
		script.push_back(cfg_row(CFG_BRIGHTNESS, 24'd50));
		script.push_back(tick_row(1'b1, 1'b0, 24'h0));
		script.push_back(tick_row(1'b1, 1'b0, 24'h0));
		// Back to spinner at low brightness
		script.push_back(cfg_row(CFG_MODE, 24'd0));
		script.push_back(cfg_row(CFG_BRIGHTNESS, 24'd7));
		script.push_back(tick_row(1'b1, 1'b0, 24'h0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script
		ticked = 1'b0;
		foreach (script[k]) begin
			if (script[k].is_cfg) begin
				if (ticked)
					drain();
				ticked = 1'b0;
				write_reg(script[k].reg_idx, script[k].data);
			end else begin
				if (ticked)
					input_gap();
				send_tick(script[k].adv, script[k].known, script[k].known_rgb);
				ticked = 1'b1;
			end
		end

		// Random phases: retune some registers while idle, then a run of ticks
		ticks = 0;
		while (ticks < TICK_TARGET) begin
			drain();
			for (int r = 0; r <= 4; r++) begin
				if ($urandom_range(0, 2) != 0) begin
					ri = lraf_cfg_idx_t'(r);
					case (ri)
						CFG_MODE: val = 24'($urandom_range(0, 1));
						CFG_COLOR_FIRST, CFG_COLOR_SECOND:
							case ($urandom_range(0, 3))
								0:       val = 24'h000000;
								1:       val = 24'hFFFFFF;
								default: val = 24'($urandom);
							endcase
						CFG_SPIN_WIDTH:
							val = 24'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
								: $urandom_range(1, 24));
						default:
							val = 24'(($urandom_range(0, 4) == 0) ? $urandom_range(101, 127)
								: $urandom_range(0, 100));
					endcase
					write_reg(ri, val);
				end
			end
			burst = $urandom_range(4, 20);
			for (int j = 0; j < burst && ticks < TICK_TARGET; j++) begin
				quiet = (ticks >= QUIET_FROM);
				if (j > 0)
					input_gap();
				send_tick($urandom_range(0, 3) != 0, 1'b0, 24'h0);
				ticks++;
			end
		end

		// Wind down
		quiet = 1'b1;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/lraf_pkg.sv
hdl/lraf_front.sv
hdl/lraf_queue.sv
hdl/lraf_back.sv
hdl/led_ring_animation_frame_unit.sv
hdl/lraf_checker.sv
tb/tb_led_ring_animation_frame_unit.sv
